>>> rtl/sbi_pkg.sv
`timescale 1ns / 1ps

package sbi_pkg;

  // Coordinate format: signed Q12.4, handled as exact integers.
  localparam int COORD_BITS  = 16;
  localparam int HALF_BITS   = COORD_BITS - 1;
  localparam int CORNER_W    = COORD_BITS + 1;
  localparam int DIFF_W      = COORD_BITS + 2;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 1;

  localparam int IN_FIELDS_W = 6 * COORD_BITS + 2 * HALF_BITS;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic signed [CORNER_W-1:0] x;
    logic signed [CORNER_W-1:0] y;
  } pt_t;

  typedef enum logic [1:0] {
    ORIENT_COL,
    ORIENT_CW,
    ORIENT_CCW
  } orient_e;

endpackage

>>> rtl/sbi_edge_test.sv
`timescale 1ns / 1ps

// Segment-vs-edge meet test. Products and bounding-box flags are registered on
// load_i; the orientation signs and the final meet decision follow that register.
module sbi_edge_test (
  input  logic          clk_i,
  input  logic          load_i,
  input  sbi_pkg::pt_t  seg_start_i,
  input  sbi_pkg::pt_t  seg_end_i,
  input  sbi_pkg::pt_t  corner_a_i,
  input  sbi_pkg::pt_t  corner_b_i,
  output logic          meet_o
);
  import sbi_pkg::*;

  // q inside the bounding rectangle of p and r, bounds included
  function automatic logic in_box(pt_t p, pt_t q, pt_t r);
    logic lo_x, hi_x, lo_y, hi_y;
    begin
      hi_x = (q.x <= p.x) || (q.x <= r.x);
      lo_x = (q.x >= p.x) || (q.x >= r.x);
      hi_y = (q.y <= p.y) || (q.y <= r.y);
      lo_y = (q.y >= p.y) || (q.y >= r.y);
      return hi_x && lo_x && hi_y && lo_y;
    end
  endfunction

  function automatic orient_e orient_of(logic signed [PROD_W-1:0] p,
                                        logic signed [PROD_W-1:0] q);
    logic signed [CROSS_W-1:0] r;
    begin
      r = CROSS_W'(p) - CROSS_W'(q);
      if (r == '0) begin
        return ORIENT_COL;
      end else if (!r[CROSS_W-1]) begin
        return ORIENT_CW;
      end else begin
        return ORIENT_CCW;
      end
    end
  endfunction

  // orient(a,b,c) for (S,E,A), (S,E,B), (A,B,S), (A,B,E)
  pt_t oa [4];
  pt_t ob [4];
  pt_t oc [4];

  assign oa[0] = seg_start_i;  assign ob[0] = seg_end_i;   assign oc[0] = corner_a_i;
  assign oa[1] = seg_start_i;  assign ob[1] = seg_end_i;   assign oc[1] = corner_b_i;
  assign oa[2] = corner_a_i;   assign ob[2] = corner_b_i;  assign oc[2] = seg_start_i;
  assign oa[3] = corner_a_i;   assign ob[3] = corner_b_i;  assign oc[3] = seg_end_i;

  logic signed [PROD_W-1:0] prod_p_d [4];
  logic signed [PROD_W-1:0] prod_q_d [4];
  logic signed [PROD_W-1:0] prod_p_q [4];
  logic signed [PROD_W-1:0] prod_q_q [4];
  logic [3:0]               box_d;
  logic [3:0]               box_q;

  for (genvar i = 0; i < 4; i++) begin : g_orient
    logic signed [DIFF_W-1:0] dy1, dx2, dx1, dy2;
    assign dy1 = DIFF_W'($signed(ob[i].y)) - DIFF_W'($signed(oa[i].y));
    assign dx2 = DIFF_W'($signed(oc[i].x)) - DIFF_W'($signed(ob[i].x));
    assign dx1 = DIFF_W'($signed(ob[i].x)) - DIFF_W'($signed(oa[i].x));
    assign dy2 = DIFF_W'($signed(oc[i].y)) - DIFF_W'($signed(ob[i].y));
    assign prod_p_d[i] = PROD_W'(dy1) * PROD_W'(dx2);
    assign prod_q_d[i] = PROD_W'(dx1) * PROD_W'(dy2);
  end

  assign box_d[0] = in_box(seg_start_i, corner_a_i, seg_end_i);
  assign box_d[1] = in_box(seg_start_i, corner_b_i, seg_end_i);
  assign box_d[2] = in_box(corner_a_i, seg_start_i, corner_b_i);
  assign box_d[3] = in_box(corner_a_i, seg_end_i, corner_b_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_p_q <= prod_p_d;
      prod_q_q <= prod_q_d;
      box_q    <= box_d;
    end
  end

  orient_e o [4];
  logic    touch;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      o[i] = orient_of(prod_p_q[i], prod_q_q[i]);
    end
    touch = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (o[i] == ORIENT_COL && box_q[i]) begin
        touch = 1'b1;
      end
    end
    meet_o = ((o[0] != o[1]) && (o[2] != o[3])) || touch;
  end

endmodule

>>> rtl/segment_box_intersect.sv
`timescale 1ns / 1ps

// Channel  | Dir | Content (tdata from bit 0 up)
// ---------+-----+------------------------------------------------------------
// s_axis   | in  | seg_start_x[15:0] seg_start_y[31:16] seg_end_x[47:32]
//          |     | seg_end_y[63:48] box_center_x[79:64] box_center_y[95:80]
//          |     | box_half_width[110:96] box_half_height[125:111], 0 pad to 128
// m_axis   | out | hit[0], 0 pad to 8
//
// One query per cycle sustained while m_axis_tready stays high. Three register
// stages (input register, product register inside each edge test, result
// register): a query passes through them in that order and is offered as a
// valid result from the result register. The path is set by corner add,
// difference and one 18x18 multiply ahead of the product register.
// Reset clears only the stage valid bits; data registers are not reset.
// Stalls: a stage loads whenever it is empty or the stage after it moves, so
// bubbles collapse and s_axis_tready drops only when all three stages are full
// and m_axis_tready is low.
module segment_box_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, box_center_x,
  // box_center_y, box_half_width, box_half_height, zero pad
  input  logic [sbi_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit, zero pad
  output logic [sbi_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import sbi_pkg::*;

  // ---- pipeline control ----
  logic in_vld_q, in_vld_d;
  logic prod_vld_q, prod_vld_d;
  logic out_vld_q, out_vld_d;
  logic en_out, en_prod, en_in;

  assign en_out  = !out_vld_q || m_axis_tready;
  assign en_prod = !prod_vld_q || en_out;
  assign en_in   = !in_vld_q || en_prod;

  assign s_axis_tready = en_in;

  assign in_vld_d   = en_in   ? s_axis_tvalid : in_vld_q;
  assign prod_vld_d = en_prod ? in_vld_q      : prod_vld_q;
  assign out_vld_d  = en_out  ? prod_vld_q    : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_d;
      prod_vld_q <= prod_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // ---- input register (padding bits dropped) ----
  logic [IN_FIELDS_W-1:0] in_q;

  always_ff @(posedge clk_i) begin
    if (en_in) begin
      in_q <= s_axis_tdata[IN_FIELDS_W-1:0];
    end
  end

  // field unpack
  logic signed [COORD_BITS-1:0] sx, sy, ex, ey, cx, cy;
  logic        [HALF_BITS-1:0]  hx, hy;

  assign sx = in_q[0*COORD_BITS +: COORD_BITS];
  assign sy = in_q[1*COORD_BITS +: COORD_BITS];
  assign ex = in_q[2*COORD_BITS +: COORD_BITS];
  assign ey = in_q[3*COORD_BITS +: COORD_BITS];
  assign cx = in_q[4*COORD_BITS +: COORD_BITS];
  assign cy = in_q[5*COORD_BITS +: COORD_BITS];
  assign hx = in_q[6*COORD_BITS +: HALF_BITS];
  assign hy = in_q[6*COORD_BITS + HALF_BITS +: HALF_BITS];

  // ---- corners, one bit wider than a coordinate: exact, never saturate ----
  logic signed [CORNER_W-1:0] cx_w, cy_w, hx_w, hy_w;
  pt_t seg_s, seg_e, p1, p2, p3, p4;

  assign cx_w = CORNER_W'(cx);
  assign cy_w = CORNER_W'(cy);
  assign hx_w = $signed(CORNER_W'(hx));
  assign hy_w = $signed(CORNER_W'(hy));

  assign seg_s.x = CORNER_W'(sx);
  assign seg_s.y = CORNER_W'(sy);
  assign seg_e.x = CORNER_W'(ex);
  assign seg_e.y = CORNER_W'(ey);

  assign p1.x = cx_w - hx_w;  assign p1.y = cy_w - hy_w;
  assign p2.x = cx_w + hx_w;  assign p2.y = cy_w - hy_w;
  assign p3.x = cx_w + hx_w;  assign p3.y = cy_w + hy_w;
  assign p4.x = cx_w - hx_w;  assign p4.y = cy_w + hy_w;

  // ---- edge tests: P1P2, P2P3, P3P4, P1P4 ----
  pt_t        edge_a [4];
  pt_t        edge_b [4];
  logic [3:0] meet;

  assign edge_a[0] = p1;  assign edge_b[0] = p2;
  assign edge_a[1] = p2;  assign edge_b[1] = p3;
  assign edge_a[2] = p3;  assign edge_b[2] = p4;
  assign edge_a[3] = p1;  assign edge_b[3] = p4;

  for (genvar i = 0; i < 4; i++) begin : g_edge
    sbi_edge_test u_edge (
      .clk_i      (clk_i),
      .load_i     (en_prod),
      .seg_start_i(seg_s),
      .seg_end_i  (seg_e),
      .corner_a_i (edge_a[i]),
      .corner_b_i (edge_b[i]),
      .meet_o     (meet[i])
    );
  end

  // ---- result register ----
  logic hit_q, hit_d;

  assign hit_d = |meet;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hit_q <= hit_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, hit_q};

endmodule

>>> rtl/sbi_checker.sv
`timescale 1ns / 1ps

module sbi_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [sbi_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [sbi_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import sbi_pkg::*;

  logic       in_xfer, out_xfer;
  logic [2:0] pend_q, pend_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign pend_d   = pend_q + 3'(in_xfer) - 3'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // no result without an outstanding query
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("result with no outstanding query");

  // at most three queries in flight
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more queries in flight than pipeline stages");

  // with the pipeline full and the output stalled, no new transfer is taken
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 3'd3 && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline full and stalled");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind segment_box_intersect sbi_checker u_sbi_checker (.*);
